FILE: src/dcfr_pkg.sv
// ----------------------------------------------------------------------------
// Delimited command frame receiver package
// Buffer sizing, delimiter bytes, command codes, frame modes and the
// buffer write port type shared by the receiver and its frame buffer.
// ----------------------------------------------------------------------------
package dcfr_pkg;

    localparam int BUFFER_DEPTH = 1024;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);

    // Item command codes.
    localparam logic [1:0] CMD_BYTE    = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    // Delimiter bytes.
    localparam logic [7:0] CH_ANGLE_OPEN  = 8'h3C; // '<'
    localparam logic [7:0] CH_ANGLE_CLOSE = 8'h3E; // '>'
    localparam logic [7:0] CH_DOLLAR      = 8'h24; // '$'
    localparam logic [7:0] CH_HASH        = 8'h23; // '#'
    localparam logic [7:0] CH_BRACE_OPEN  = 8'h7B; // '{'
    localparam logic [7:0] CH_BRACE_CLOSE = 8'h7D; // '}'
    localparam logic [7:0] CH_BANG        = 8'h21; // '!'
    localparam logic [7:0] CH_NUL         = 8'h00;

    // Reported frame kind codes.
    localparam logic [2:0] KIND_IDLE   = 3'd0;
    localparam logic [2:0] KIND_DOLLAR = 3'd1;
    localparam logic [2:0] KIND_HASH   = 3'd2;
    localparam logic [2:0] KIND_BRACE  = 3'd3;
    localparam logic [2:0] KIND_ANGLE  = 3'd4;

    typedef enum logic [4:0] {
        MODE_IDLE   = 5'b00001,
        MODE_DOLLAR = 5'b00010,
        MODE_HASH   = 5'b00100,
        MODE_BRACE  = 5'b01000,
        MODE_ANGLE  = 5'b10000
    } t_mode;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_buf_wr;

    function automatic logic [2:0] mode_to_kind(input t_mode mode);
        logic [2:0] kind;
        unique case (mode)
            MODE_DOLLAR: kind = KIND_DOLLAR;
            MODE_HASH:   kind = KIND_HASH;
            MODE_BRACE:  kind = KIND_BRACE;
            MODE_ANGLE:  kind = KIND_ANGLE;
            default:     kind = KIND_IDLE;
        endcase
        return kind;
    endfunction

    function automatic logic is_terminator(input t_mode mode, input logic [7:0] b);
        logic hit;
        unique case (mode)
            MODE_ANGLE:  hit = (b == CH_ANGLE_CLOSE);
            MODE_DOLLAR: hit = (b == CH_BANG);
            MODE_HASH:   hit = (b == CH_BANG);
            MODE_BRACE:  hit = (b == CH_BRACE_CLOSE);
            default:     hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

FILE: src/dcfr_frame_buffer.sv
// ----------------------------------------------------------------------------
// Frame buffer
// Single-port-write, single-port-read byte memory with registered read data.
// ----------------------------------------------------------------------------
module dcfr_frame_buffer
    import dcfr_pkg::*;
(
    input  logic              i_clk,
    input  t_buf_wr           i_wr,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [BUFFER_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/delimited_command_frame_receiver.sv
// ----------------------------------------------------------------------------
// Delimited command frame receiver
// Assembles one delimited command frame from received bytes into a buffer.
// ----------------------------------------------------------------------------
// Every input transfer produces exactly one output transfer that reports the
// status after the command. One item is accepted per cycle while the output
// is not stalled: an input register feeds the frame logic and the buffer, and
// an output register holds the result, so the rate is set by the single
// buffer write port, which takes one byte per cycle. The terminating zero of
// a frame is committed to the buffer in the cycle after the terminator, when
// no byte write can follow because the frame is then waiting for release; a
// read of that entry in that cycle returns zero. Reading an entry that was
// never written returns undefined data.
module delimited_command_frame_receiver
    import dcfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // rx_byte[7:0], read_index[17:8], zero pad
    input  logic [1:0]  i_s_tuser,  // command[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata   // frame_ready[0], frame_kind[3:1],
                                    // frame_length[13:4], byte_dropped[14],
                                    // read_data[22:15], zero pad
);

    // Input register.
    logic        r_s1_valid;
    logic [1:0]  r_s1_cmd;
    logic [7:0]  r_s1_byte;
    logic [9:0]  r_s1_rdidx;

    // Frame state.
    t_mode             r_mode, n_mode;
    logic [ADDR_W-1:0] r_widx, n_widx;
    logic              r_ready, n_ready;
    logic              r_pend_valid, n_pend_valid;
    logic [ADDR_W-1:0] r_pend_addr, n_pend_addr;

    // Output register.
    logic        r_s2_valid;
    logic        r_s2_ready;
    logic [2:0]  r_s2_kind;
    logic [9:0]  r_s2_len;
    logic        r_s2_drop;
    logic        r_s2_rd_ok;

    logic              s2_load;
    logic              s1_fire;
    logic              in_fire;
    logic              drop;
    logic              rd_ok;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W:0]   base_inc;
    t_buf_wr           buf_wr;
    logic [7:0]        rd_data;

    assign s2_load    = !r_s2_valid || i_m_tready;
    assign s1_fire    = r_s1_valid && s2_load;
    assign o_s_tready = !r_s1_valid || s2_load;
    assign in_fire    = i_s_tvalid && o_s_tready;

    assign rd_addr = ADDR_W'(r_s1_rdidx);

    always_comb begin
        n_mode       = r_mode;
        n_widx       = r_widx;
        n_ready      = r_ready;
        n_pend_valid = 1'b0;
        n_pend_addr  = r_pend_addr;
        drop         = 1'b0;
        rd_ok        = 1'b0;
        base         = r_widx;
        base_inc     = '0;
        buf_wr.en    = 1'b0;
        buf_wr.addr  = r_pend_addr;
        buf_wr.data  = CH_NUL;

        // The pending zero is written the cycle after its terminator.
        if (r_pend_valid) begin
            buf_wr.en = 1'b1;
        end

        if (s1_fire) begin
            case (r_s1_cmd)
                CMD_BYTE: begin
                    if (r_ready) begin
                        drop = 1'b1;
                    end else begin
                        if (r_s1_byte == CH_ANGLE_OPEN) begin
                            n_mode = MODE_ANGLE;
                            base   = '0;
                        end else if (r_mode == MODE_IDLE) begin
                            if (r_s1_byte == CH_DOLLAR) begin
                                n_mode = MODE_DOLLAR;
                            end else if (r_s1_byte == CH_HASH) begin
                                n_mode = MODE_HASH;
                            end else if (r_s1_byte == CH_BRACE_OPEN) begin
                                n_mode = MODE_BRACE;
                            end
                            base = '0;
                        end
                        buf_wr.en   = 1'b1;
                        buf_wr.addr = base;
                        buf_wr.data = r_s1_byte;
                        base_inc    = {1'b0, base} + (ADDR_W+1)'(1);
                        if (base_inc == (ADDR_W+1)'(BUFFER_DEPTH)) begin
                            n_widx = '0;
                        end else begin
                            n_widx = base_inc[ADDR_W-1:0];
                        end
                        if (is_terminator(n_mode, r_s1_byte)) begin
                            n_ready      = 1'b1;
                            n_pend_valid = 1'b1;
                            n_pend_addr  = n_widx;
                        end
                    end
                end
                CMD_RELEASE: begin
                    n_ready = 1'b0;
                    n_mode  = MODE_IDLE;
                end
                CMD_READ: begin
                    // A read that meets the zero still being written sees zero.
                    rd_ok = (32'(r_s1_rdidx) < BUFFER_DEPTH)
                            && !(r_pend_valid && (r_pend_addr == rd_addr));
                end
                default: begin
                end
            endcase
        end
    end

    dcfr_frame_buffer u_buffer (
        .i_clk     (i_clk),
        .i_wr      (buf_wr),
        .i_rd_en   (s1_fire),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_mode       <= MODE_IDLE;
            r_widx       <= '0;
            r_ready      <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_s1_valid <= i_s_tvalid;
            end
            if (s2_load) begin
                r_s2_valid <= r_s1_valid;
            end
            r_mode       <= n_mode;
            r_widx       <= n_widx;
            r_ready      <= n_ready;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr <= n_pend_addr;
        if (in_fire) begin
            r_s1_cmd   <= i_s_tuser;
            r_s1_byte  <= i_s_tdata[7:0];
            r_s1_rdidx <= i_s_tdata[17:8];
        end
        if (s1_fire) begin
            r_s2_ready <= n_ready;
            r_s2_kind  <= mode_to_kind(n_mode);
            r_s2_len   <= 10'(n_widx);
            r_s2_drop  <= drop;
            r_s2_rd_ok <= rd_ok;
        end
    end

    assign o_m_tvalid = r_s2_valid;
    assign o_m_tdata  = {1'b0,
                         (r_s2_rd_ok ? rd_data : 8'h00),
                         r_s2_drop,
                         r_s2_len,
                         r_s2_kind,
                         r_s2_ready};

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Delimited command frame receiver testbench
// Directed table followed by random frames and noise. Each output transfer
// is checked field by field against an in-bench model of the frame state and
// buffer, or against a typed row's own status. Both stream sides idle.
// ----------------------------------------------------------------------------
module tb_top
    import dcfr_pkg::*;
();

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Result fields, packed from frame_ready in the lowest bit upward.
    typedef struct packed {
        logic [7:0]  read_data;
        logic        byte_dropped;
        logic [9:0]  frame_length;
        logic [2:0]  frame_kind;
        logic        frame_ready;
    } t_frame_status;

    typedef struct {
        logic [1:0]    cmd;
        logic [7:0]    rx;
        logic [9:0]    idx;
        bit            typed;
        t_frame_status want;
    } t_stim_row;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata  = '0;  // rx_byte[7:0], read_index[17:8], zero pad
    logic [1:0]  i_s_tuser  = '0;  // command[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;        // frame_ready[0], frame_kind[3:1],
                                   // frame_length[13:4], byte_dropped[14],
                                   // read_data[22:15], zero pad

    delimited_command_frame_receiver dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Frame state as seen by the bench.
    logic [2:0]        cur_kind = KIND_IDLE;
    logic [ADDR_W-1:0] wr_idx   = '0;
    logic              held     = 1'b0;
    logic [7:0]        shadow_buf [BUFFER_DEPTH];
    bit                stored     [BUFFER_DEPTH];

    t_frame_status pending_status [$];
    t_stim_row     directed_rows [$];
    int            items_sent     = 0;
    int            src_idle_pct   = 0;
    int            sink_stall_pct = 0;
    bit            failed         = 1'b0;

    function automatic t_frame_status status(input logic r, input logic [2:0] k,
                                             input logic [9:0] n, input logic d,
                                             input logic [7:0] data);
        t_frame_status st;
        st.frame_ready  = r;
        st.frame_kind   = k;
        st.frame_length = n;
        st.byte_dropped = d;
        st.read_data    = data;
        return st;
    endfunction

    function automatic t_frame_status predict_frame_status(input logic [1:0] cmd,
                                                           input logic [7:0] rx,
                                                           input logic [9:0] idx);
        t_frame_status st;
        logic          hit;
        st = '0;
        case (cmd)
            CMD_BYTE: begin
                if (held) begin
                    st.byte_dropped = 1'b1;
                end else begin
                    if (rx == CH_ANGLE_OPEN) begin
                        cur_kind = KIND_ANGLE;
                        wr_idx   = '0;
                    end else if (cur_kind == KIND_IDLE) begin
                        if (rx == CH_DOLLAR)
                            cur_kind = KIND_DOLLAR;
                        else if (rx == CH_HASH)
                            cur_kind = KIND_HASH;
                        else if (rx == CH_BRACE_OPEN)
                            cur_kind = KIND_BRACE;
                        wr_idx = '0;
                    end
                    shadow_buf[wr_idx] = rx;
                    stored[wr_idx]     = 1'b1;
                    wr_idx = (wr_idx == BUFFER_DEPTH - 1) ? '0 : wr_idx + 1'b1;
                    case (cur_kind)
                        KIND_ANGLE:             hit = (rx == CH_ANGLE_CLOSE);
                        KIND_DOLLAR, KIND_HASH: hit = (rx == CH_BANG);
                        KIND_BRACE:             hit = (rx == CH_BRACE_CLOSE);
                        default:                hit = 1'b0;
                    endcase
                    // The closing zero lands after the terminator, wrapping too.
                    if (hit) begin
                        shadow_buf[wr_idx] = CH_NUL;
                        stored[wr_idx]     = 1'b1;
                        held               = 1'b1;
                    end
                end
            end
            CMD_RELEASE: begin
                held     = 1'b0;
                cur_kind = KIND_IDLE;
            end
            CMD_READ: begin
                st.read_data = shadow_buf[idx];
            end
            default: ;
        endcase
        st.frame_ready  = held;
        st.frame_kind   = cur_kind;
        st.frame_length = wr_idx;
        return st;
    endfunction

    function automatic void add_row(input logic [1:0] cmd, input logic [7:0] rx,
                                    input logic [9:0] idx, input bit typed = 1'b0,
                                    input t_frame_status want = '0);
        t_stim_row row;
        row.cmd   = cmd;
        row.rx    = rx;
        row.idx   = idx;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    // Picks an entry that has been written, favoring the current frame.
    function automatic bit pick_read_index(output logic [9:0] idx);
        for (int t = 0; t < 32; t++) begin
            if (t < 16 && wr_idx != 0)
                idx = 10'($urandom_range(int'(wr_idx), 0));
            else
                idx = 10'($urandom_range(BUFFER_DEPTH - 1, 0));
            if (stored[idx])
                return 1'b1;
        end
        idx = '0;
        return stored[0];
    endfunction

    function automatic logic [7:0] body_byte(input logic [7:0] term);
        logic [7:0] b;
        do
            b = 8'($urandom_range(255, 0));
        while (b == CH_ANGLE_OPEN || b == term);
        return b;
    endfunction

    // Presents one item and waits for its transfer; the expectation is
    // recorded just before the accepting edge.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] rx,
                             input logic [9:0] idx, input bit typed = 1'b0,
                             input t_frame_status want = '0);
        t_frame_status pred;
        bit            took;
        if ($urandom_range(99, 0) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(99, 0) < src_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {6'b0, idx, rx};
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = o_s_tready;
            if (took) begin
                pred = predict_frame_status(cmd, rx, idx);
                pending_status.push_back(typed ? want : pred);
            end
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    task automatic send_read_or_unused();
        logic [9:0] idx;
        if (pick_read_index(idx))
            send_item(CMD_READ, 8'($urandom_range(255, 0)), idx);
        else
            send_item(CMD_UNUSED, 8'($urandom_range(255, 0)),
                      10'($urandom_range(1023, 0)));
    endtask

    task automatic send_noise();
        logic [1:0] cmd;
        cmd = 2'($urandom_range(3, 0));
        if (cmd == CMD_READ)
            send_read_or_unused();
        else
            send_item(cmd, 8'($urandom_range(255, 0)), 10'($urandom_range(1023, 0)));
    endtask

    task automatic send_frame();
        logic [7:0] openers [4];
        logic [7:0] closers [4];
        logic [7:0] b;
        int         k;
        int         body_len;
        openers = '{CH_DOLLAR, CH_HASH, CH_BRACE_OPEN, CH_ANGLE_OPEN};
        closers = '{CH_BANG, CH_BANG, CH_BRACE_CLOSE, CH_ANGLE_CLOSE};
        k = $urandom_range(3, 0);
        // Stray bytes in idle only overwrite entry 0.
        if ($urandom_range(3, 0) == 0) begin
            repeat ($urandom_range(3, 1)) begin
                do
                    b = 8'($urandom_range(255, 0));
                while (b == CH_ANGLE_OPEN || b == CH_DOLLAR || b == CH_HASH ||
                       b == CH_BRACE_OPEN);
                send_item(CMD_BYTE, b, 10'($urandom_range(1023, 0)));
            end
        end
        send_item(CMD_BYTE, openers[k], 10'($urandom_range(1023, 0)));
        body_len = $urandom_range(12, 0);
        repeat (body_len) begin
            if ($urandom_range(9, 0) == 0)
                b = closers[(k + $urandom_range(3, 1)) % 4];
            else
                b = body_byte(closers[k]);
            if (b == closers[k])
                b = CH_HASH;
            send_item(CMD_BYTE, b, 10'($urandom_range(1023, 0)));
        end
        send_item(CMD_BYTE, closers[k], 10'($urandom_range(1023, 0)));
        repeat ($urandom_range(3, 0)) begin
            if ($urandom_range(1, 0) == 0)
                send_read_or_unused();
            else
                send_item(CMD_BYTE, 8'($urandom_range(255, 0)),
                          10'($urandom_range(1023, 0)));
        end
        if ($urandom_range(9, 0) != 0)
            send_item(CMD_RELEASE, 8'($urandom_range(255, 0)),
                      10'($urandom_range(1023, 0)));
    endtask

    always @(posedge i_clk)
        i_m_tready <= ($urandom_range(99, 0) >= sink_stall_pct);

    always @(posedge i_clk) begin
        t_frame_status got;
        t_frame_status want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_frame_status'(o_m_tdata[22:0]);
            if (pending_status.size() == 0) begin
                $error("unexpected result transfer: tdata %h", o_m_tdata);
                failed = 1'b1;
            end else begin
                want = pending_status.pop_front();
                if (got.frame_ready !== want.frame_ready) begin
                    $error("frame_ready: expected %0d, got %0d",
                           want.frame_ready, got.frame_ready);
                    failed = 1'b1;
                end
                if (got.frame_kind !== want.frame_kind) begin
                    $error("frame_kind: expected %0d, got %0d",
                           want.frame_kind, got.frame_kind);
                    failed = 1'b1;
                end
                if (got.frame_length !== want.frame_length) begin
                    $error("frame_length: expected %0d, got %0d",
                           want.frame_length, got.frame_length);
                    failed = 1'b1;
                end
                if (got.byte_dropped !== want.byte_dropped) begin
                    $error("byte_dropped: expected %0d, got %0d",
                           want.byte_dropped, got.byte_dropped);
                    failed = 1'b1;
                end
                if (got.read_data !== want.read_data) begin
                    $error("read_data: expected %h, got %h",
                           want.read_data, got.read_data);
                    failed = 1'b1;
                end
                if (o_m_tdata[23] !== 1'b0) begin
                    $error("pad: expected 0, got %b", o_m_tdata[23]);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        int idle_plan  [4];
        int stall_plan [4];
        int target;
        idle_plan  = '{0, 79, 0, 26};
        stall_plan = '{0, 0, 79, 26};

        add_row(CMD_UNUSED, 8'hFF, 10'h3FF, 1'b1,
                status(1'b0, KIND_IDLE, 10'd0, 1'b0, 8'h00));
        add_row(CMD_BYTE, 8'h41, 10'd0, 1'b1,
                status(1'b0, KIND_IDLE, 10'd1, 1'b0, 8'h00));
        add_row(CMD_BYTE, 8'h00, 10'd0, 1'b1,
                status(1'b0, KIND_IDLE, 10'd1, 1'b0, 8'h00));
        add_row(CMD_BYTE, 8'hFF, 10'd0, 1'b1,
                status(1'b0, KIND_IDLE, 10'd1, 1'b0, 8'h00));
        add_row(CMD_READ, 8'h00, 10'd0, 1'b1,
                status(1'b0, KIND_IDLE, 10'd1, 1'b0, 8'hFF));
        add_row(CMD_BYTE, CH_DOLLAR, 10'd0);
        add_row(CMD_BYTE, 8'h78, 10'd0);
        // Terminators of other frame kinds are plain data here.
        add_row(CMD_BYTE, CH_BRACE_CLOSE, 10'd0);
        add_row(CMD_BYTE, CH_ANGLE_CLOSE, 10'd0);
        add_row(CMD_BYTE, CH_BANG, 10'd0);
        add_row(CMD_BYTE, 8'h7A, 10'd0, 1'b1,
                status(1'b1, KIND_DOLLAR, 10'd5, 1'b1, 8'h00));
        add_row(CMD_READ, 8'h00, 10'd5, 1'b1,
                status(1'b1, KIND_DOLLAR, 10'd5, 1'b0, CH_NUL));
        add_row(CMD_READ, 8'h00, 10'd4);
        add_row(CMD_RELEASE, 8'h00, 10'd0, 1'b1,
                status(1'b0, KIND_IDLE, 10'd5, 1'b0, 8'h00));
        add_row(CMD_BYTE, CH_HASH, 10'd0);
        add_row(CMD_BYTE, CH_BANG, 10'd0);
        add_row(CMD_RELEASE, 8'h00, 10'd0);
        add_row(CMD_BYTE, CH_BRACE_OPEN, 10'd0);
        add_row(CMD_BYTE, CH_BANG, 10'd0);
        add_row(CMD_BYTE, CH_BRACE_CLOSE, 10'd0);
        add_row(CMD_BYTE, CH_ANGLE_OPEN, 10'd0, 1'b1,
                status(1'b1, KIND_BRACE, 10'd3, 1'b1, 8'h00));
        add_row(CMD_RELEASE, 8'h00, 10'd0);
        // An angle opener restarts whatever frame is open.
        add_row(CMD_BYTE, CH_DOLLAR, 10'd0);
        add_row(CMD_BYTE, CH_ANGLE_OPEN, 10'd0);
        add_row(CMD_BYTE, CH_BRACE_OPEN, 10'd0);
        add_row(CMD_BYTE, CH_ANGLE_OPEN, 10'd0);
        add_row(CMD_BYTE, CH_ANGLE_CLOSE, 10'd0);
        add_row(CMD_RELEASE, 8'h00, 10'd0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].rx, directed_rows[i].idx,
                      directed_rows[i].typed, directed_rows[i].want);

        for (int p = 0; p < 4; p++) begin
            src_idle_pct   = idle_plan[p];
            sink_stall_pct = stall_plan[p];
            target = items_sent + 175;
            while (items_sent < target) begin
                if ($urandom_range(99, 0) < 75)
                    send_frame();
                else
                    repeat ($urandom_range(4, 1))
                        send_noise();
            end
        end

        i_s_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (!failed)
            $display("** delimited_command_frame_receiver: PASSED **");
        else
            $display("** delimited_command_frame_receiver: FAILED **");
        $finish;
    end

    initial begin
        #400000;
        $display("** delimited_command_frame_receiver: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
src/dcfr_pkg.sv
src/dcfr_frame_buffer.sv
src/delimited_command_frame_receiver.sv
tb/tb_top.sv
